[design/kalman_angle_bias_filter_core_assert.svh]
// Assertion macros shared by the checker of the angle and bias filter.
`ifndef KALMAN_ANGLE_BIAS_FILTER_CORE_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define KABF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kabf check failed");

// The consequent must hold in the same cycle as the antecedent.
`define KABF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kabf check failed");

`endif

[design/kabf_pkg.sv]
// Types, widths, constants and helper functions of the angle and bias filter.
package kabf_pkg;

  localparam int unsigned MEAS_W    = 25;
  localparam int unsigned RATE_W    = 25;
  localparam int unsigned DT_W      = 25;
  localparam int unsigned EST_W     = 32;
  localparam int unsigned NOISE_W   = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DT_FRAC   = 24;

  // Serial multiplier: signed multiplicand, unsigned magnitude multiplier.
  localparam int unsigned MA_W      = 36;
  localparam int unsigned MB_W      = 32;
  localparam int unsigned PROD_W    = MA_W + MB_W;
  localparam int unsigned MUL_CNT_W = $clog2(MB_W);
  localparam int unsigned SUM_W     = PROD_W + 2;

  // Divider operands: numerator is a covariance, denominator P00 + R.
  localparam int unsigned DEN_W     = EST_W + 1;

  localparam logic [NOISE_W-1:0] Q_ANGLE_RST = NOISE_W'(16777);
  localparam logic [NOISE_W-1:0] Q_BIAS_RST  = NOISE_W'(50332);
  localparam logic [NOISE_W-1:0] R_MEAS_RST  = NOISE_W'(503316);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Q_ANGLE = 2'd0,
    CFG_Q_BIAS  = 2'd1,
    CFG_R_MEAS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ANGLE,
    ST_MUL_P11,
    ST_MUL_INNER,
    ST_MUL_QBIAS,
    ST_DIV_K0,
    ST_DIV_K1,
    ST_MUL_K0Y,
    ST_MUL_K1Y,
    ST_MUL_K0N00,
    ST_MUL_K0N01,
    ST_MUL_K1N00,
    ST_MUL_K1N01,
    ST_WAIT_OUT
  } state_e;

  typedef struct packed {
    logic                     start;
    logic signed [MA_W-1:0]   a;
    logic        [MB_W-1:0]   b;
    logic                     neg;
  } mul_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [EST_W-1:0]  num;
    logic signed [DEN_W-1:0]  den;
  } div_req_t;

  function automatic logic signed [EST_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [EST_W-1:0] r;
    if ((&v[SUM_W-1:EST_W-1]) || !(|v[SUM_W-1:EST_W-1])) begin
      r = v[EST_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(EST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[design/kabf_in_if.sv]
// Input channel carrying one sensor sample.
interface kabf_in_if
  import kabf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measured_angle;
  logic signed [RATE_W-1:0] rate;
  logic        [DT_W-1:0]   step_time;

  modport source (output valid, measured_angle, rate, step_time, input ready);
  modport sink   (input valid, measured_angle, rate, step_time, output ready);
endinterface

[design/kabf_out_if.sv]
// Output channel carrying the filtered angle and the bias estimate.
interface kabf_out_if
  import kabf_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] filtered_angle;
  logic signed [EST_W-1:0] gyro_bias;

  modport source (output valid, filtered_angle, gyro_bias, input ready);
  modport sink   (input valid, filtered_angle, gyro_bias, output ready);
endinterface

[design/kabf_cfg_if.sv]
// Configuration write channel.
interface kabf_cfg_if
  import kabf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NOISE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/kalman_angle_bias_filter_core.sv]
// Two-state Kalman filter for angle and gyro bias. One sample is taken at a time; an update
// runs ten multiplications on a bit-serial multiplier (a start, a shift-add step per
// multiplier bit and a done strobe) and two gain divisions on a restoring divider (one
// quotient bit per cycle), then loads the output register once it is free and returns to
// idle, where the next sample is taken; a result that waits unread can hold back the load.
// The result sits in an output register, so the next sample is taken while a finished
// result still waits; configuration writes are taken at any time.
module kalman_angle_bias_filter_core
  import kabf_pkg::*;
#(
  parameter int unsigned COV_FRAC_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kabf_cfg_if.sink   cfg_i,
  kabf_in_if.sink    in_i,
  kabf_out_if.source out_o
);

  state_e state_q, state_d;
  logic   op_start_q, op_start_d;

  logic [NOISE_W-1:0] q_angle_q, q_bias_q, r_meas_q;

  logic signed [EST_W-1:0]  angle_q, bias_q;
  logic signed [EST_W-1:0]  p00_q, p01_q, p10_q, p11_q;
  logic signed [EST_W-1:0]  n00_q, n01_q, n10_q, n11_q;
  logic signed [EST_W-1:0]  k0_q, k1_q, y_q;
  logic signed [EST_W+1:0]  dtp11_q;
  logic signed [MEAS_W-1:0] meas_q;
  logic signed [RATE_W-1:0] rate_q;
  logic        [DT_W-1:0]   dt_q;

  logic                     out_valid_q;
  logic signed [EST_W-1:0]  out_angle_q, out_bias_q;

  mul_req_t                 mul_req;
  div_req_t                 div_req;
  logic                     mul_done, div_done;
  logic signed [PROD_W-1:0] prod;
  logic signed [EST_W-1:0]  quot;
  logic signed [PROD_W-1:0] sh_dt, sh_cov;
  logic signed [MA_W-1:0]   inner;
  logic signed [DEN_W-1:0]  s_den;
  logic signed [EST_W-1:0]  y_new;
  logic                     in_xfer, out_load, is_mul, is_div;

  kabf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  kabf_div #(
    .FRAC_BITS (COV_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_load = (state_q == ST_WAIT_OUT) && (!out_valid_q || out_o.ready);

  assign sh_dt  = prod >>> DT_FRAC;
  assign sh_cov = prod >>> COV_FRAC_BITS;
  assign inner  = MA_W'(dtp11_q) - MA_W'(p01_q) - MA_W'(p10_q) + signed'(MA_W'(q_angle_q));
  assign s_den  = DEN_W'(n00_q) + signed'(DEN_W'(r_meas_q));
  assign y_new  = sat32(SUM_W'(meas_q) - SUM_W'(angle_q));

  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    case (state_q)
      ST_MUL_ANGLE, ST_MUL_P11, ST_MUL_INNER, ST_MUL_QBIAS, ST_MUL_K0Y, ST_MUL_K1Y,
      ST_MUL_K0N00, ST_MUL_K0N01, ST_MUL_K1N00, ST_MUL_K1N01: is_mul = 1'b1;
      ST_DIV_K0, ST_DIV_K1: is_div = 1'b1;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_xfer) state_d = ST_MUL_ANGLE;
      ST_MUL_ANGLE: if (mul_done) state_d = ST_MUL_P11;
      ST_MUL_P11:   if (mul_done) state_d = ST_MUL_INNER;
      ST_MUL_INNER: if (mul_done) state_d = ST_MUL_QBIAS;
      ST_MUL_QBIAS: if (mul_done) state_d = ST_DIV_K0;
      ST_DIV_K0:    if (div_done) state_d = ST_DIV_K1;
      ST_DIV_K1:    if (div_done) state_d = ST_MUL_K0Y;
      ST_MUL_K0Y:   if (mul_done) state_d = ST_MUL_K1Y;
      ST_MUL_K1Y:   if (mul_done) state_d = ST_MUL_K0N00;
      ST_MUL_K0N00: if (mul_done) state_d = ST_MUL_K0N01;
      ST_MUL_K0N01: if (mul_done) state_d = ST_MUL_K1N00;
      ST_MUL_K1N00: if (mul_done) state_d = ST_MUL_K1N01;
      ST_MUL_K1N01: if (mul_done) state_d = ST_WAIT_OUT;
      ST_WAIT_OUT:  if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
    op_start_d = (state_d != state_q) && (state_d != ST_IDLE) && (state_d != ST_WAIT_OUT);
  end

  // Operand selection for the shared arithmetic units.
  always_comb begin
    in_i.ready    = (state_q == ST_IDLE);
    cfg_i.ready   = 1'b1;
    mul_req.start = op_start_q && is_mul;
    mul_req.a     = MA_W'(p11_q);
    mul_req.b     = MB_W'(dt_q);
    mul_req.neg   = 1'b0;
    div_req.start = op_start_q && is_div;
    div_req.num   = (state_q == ST_DIV_K1) ? n10_q : n00_q;
    div_req.den   = s_den;
    case (state_q)
      ST_MUL_ANGLE: mul_req.a = MA_W'(rate_q) - MA_W'(bias_q);
      ST_MUL_P11:   mul_req.a = MA_W'(p11_q);
      ST_MUL_INNER: mul_req.a = inner;
      ST_MUL_QBIAS: mul_req.a = signed'(MA_W'(q_bias_q));
      ST_MUL_K0Y, ST_MUL_K1Y: begin
        mul_req.a   = MA_W'((state_q == ST_MUL_K0Y) ? k0_q : k1_q);
        mul_req.b   = y_q[EST_W-1] ? MB_W'(-y_q) : MB_W'(y_q);
        mul_req.neg = y_q[EST_W-1];
      end
      ST_MUL_K0N00, ST_MUL_K1N00: begin
        mul_req.a   = MA_W'((state_q == ST_MUL_K0N00) ? k0_q : k1_q);
        mul_req.b   = n00_q[EST_W-1] ? MB_W'(-n00_q) : MB_W'(n00_q);
        mul_req.neg = n00_q[EST_W-1];
      end
      ST_MUL_K0N01, ST_MUL_K1N01: begin
        mul_req.a   = MA_W'((state_q == ST_MUL_K0N01) ? k0_q : k1_q);
        mul_req.b   = n01_q[EST_W-1] ? MB_W'(-n01_q) : MB_W'(n01_q);
        mul_req.neg = n01_q[EST_W-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      q_angle_q   <= Q_ANGLE_RST;
      q_bias_q    <= Q_BIAS_RST;
      r_meas_q    <= R_MEAS_RST;
      angle_q     <= '0;
      bias_q      <= '0;
      p00_q       <= '0;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= '0;
    end else begin
      state_q    <= state_d;
      op_start_q <= op_start_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_Q_ANGLE: q_angle_q <= cfg_i.data;
          CFG_Q_BIAS:  q_bias_q  <= cfg_i.data;
          CFG_R_MEAS:  r_meas_q  <= cfg_i.data;
          default: ;
        endcase
      end
      if (mul_done) begin
        case (state_q)
          ST_MUL_ANGLE: angle_q <= sat32(SUM_W'(angle_q) + SUM_W'(sh_dt));
          ST_MUL_K0Y:   angle_q <= sat32(SUM_W'(angle_q) + SUM_W'(sh_cov));
          ST_MUL_K1Y:   bias_q  <= sat32(SUM_W'(bias_q) + SUM_W'(sh_cov));
          ST_MUL_K0N00: p00_q   <= sat32(SUM_W'(n00_q) - SUM_W'(sh_cov));
          ST_MUL_K0N01: p01_q   <= sat32(SUM_W'(n01_q) - SUM_W'(sh_cov));
          ST_MUL_K1N00: p10_q   <= sat32(SUM_W'(n10_q) - SUM_W'(sh_cov));
          ST_MUL_K1N01: p11_q   <= sat32(SUM_W'(n11_q) - SUM_W'(sh_cov));
          default: ;
        endcase
      end
    end
  end

  // Working registers of one update.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      meas_q <= in_i.measured_angle;
      rate_q <= in_i.rate;
      dt_q   <= in_i.step_time;
    end
    if (mul_done) begin
      case (state_q)
        ST_MUL_P11: begin
          dtp11_q <= (EST_W + 2)'(sh_dt);
          n01_q   <= sat32(SUM_W'(p01_q) - SUM_W'(sh_dt));
          n10_q   <= sat32(SUM_W'(p10_q) - SUM_W'(sh_dt));
        end
        ST_MUL_INNER: n00_q <= sat32(SUM_W'(p00_q) + SUM_W'(sh_dt));
        ST_MUL_QBIAS: n11_q <= sat32(SUM_W'(p11_q) + SUM_W'(sh_dt));
        default: ;
      endcase
    end
    if (div_done) begin
      if (state_q == ST_DIV_K0) begin
        k0_q <= quot;
        y_q  <= y_new;
      end else begin
        k1_q <= quot;
      end
    end
    if (out_load) begin
      out_angle_q <= angle_q;
      out_bias_q  <= bias_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_angle = out_angle_q;
  assign out_o.gyro_bias      = out_bias_q;

endmodule

[design/kabf_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module kabf_mul
  import kabf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mul_req_t                 req_i,
  output logic                     done_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic                     neg_q, neg_d;
  logic [MUL_CNT_W-1:0]     cnt_q, cnt_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] mcand_q, mcand_d;
  logic [MB_W-1:0]          mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      neg_d    = req_i.neg;
      cnt_d    = '0;
      acc_d    = '0;
      mcand_d  = PROD_W'(req_i.a);
      mplier_d = req_i.b;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MB_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -acc_q : acc_q;

endmodule

[design/kabf_div.sv]
// Restoring divider for the gains, one quotient bit per cycle, saturated to 32 bits.
module kabf_div
  import kabf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output logic                    done_o,
  output logic signed [EST_W-1:0] quot_o
);

  localparam int unsigned N_W   = EST_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(N_W);
  localparam int unsigned REM_W = DEN_W + 1;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               neg_q, neg_d;
  logic               zero_q, zero_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [N_W-1:0]     quo_q, quo_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [DEN_W-1:0]   dmag_q, dmag_d;
  logic [REM_W-1:0]   rem_sh;
  logic [EST_W-1:0]   num_mag;
  logic               ovf;

  assign num_mag = req_i.num[EST_W-1] ? EST_W'(-req_i.num) : EST_W'(req_i.num);
  assign rem_sh  = {rem_q[REM_W-2:0], quo_q[N_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dmag_d = dmag_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.num[EST_W-1] ^ req_i.den[DEN_W-1];
      zero_d = (req_i.den == '0);
      cnt_d  = '0;
      quo_d  = {num_mag, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      dmag_d = req_i.den[DEN_W-1] ? DEN_W'(-req_i.den) : DEN_W'(req_i.den);
    end else if (busy_q) begin
      if (rem_sh >= REM_W'(dmag_q)) begin
        rem_d = rem_sh - REM_W'(dmag_q);
        quo_d = {quo_q[N_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dmag_q <= dmag_d;
  end

  // A negative quotient may reach magnitude 2^31, a positive one only 2^31 - 1.
  always_comb begin
    if (neg_q) begin
      ovf = (|quo_q[N_W-1:EST_W]) || (quo_q[EST_W-1] && (|quo_q[EST_W-2:0]));
    end else begin
      ovf = |quo_q[N_W-1:EST_W-1];
    end
    if (zero_q) begin
      quot_o = '0;
    end else if (ovf) begin
      quot_o = neg_q ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
    end else begin
      quot_o = neg_q ? -signed'(quo_q[EST_W-1:0]) : signed'(quo_q[EST_W-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

[design/kabf_checker.sv]
// Port-level checks of the angle and bias filter, bound to the top level.
`include "kalman_angle_bias_filter_core_assert.svh"

module kabf_checker
  import kabf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [EST_W-1:0] out_angle_i,
  input logic [EST_W-1:0] out_bias_i
);

  logic in_xfer, out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // One sample at a time: the block is busy right after taking a sample.
  `KABF_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, !in_ready_i)
  // An update cannot produce its result in the cycle after the sample is taken.
  `KABF_ASSERT_NEXT(a_no_quick_out, clk_i, rst_ni, in_xfer, !$rose(out_valid_i))
  `KABF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `KABF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall,
                    $stable(out_angle_i) && $stable(out_bias_i))

endmodule

bind kalman_angle_bias_filter_core kabf_checker u_kabf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_angle_i (out_o.filtered_angle),
  .out_bias_i  (out_o.gyro_bias)
);
